>>> rtl/core/hold_to_draw_gesture_recognizer_top_defines.svh
// assertion macros shared by the gesture recognizer modules
// each macro expects clk and arst_n in the scope where it is used
`ifndef HOLD_TO_DRAW_GESTURE_RECOGNIZER_TOP_DEFINES_SVH
`define HOLD_TO_DRAW_GESTURE_RECOGNIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HDGR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HDGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HDGR_ASSERT_IMPL(lbl, ante, cons, msg)
`define HDGR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/hdgr_pkg.sv
`default_nettype none

package hdgr_pkg;

	// field widths
	localparam int COORD_BITS   = 16;
	localparam int TIME_BITS    = 32;
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 2;

	// distance arithmetic widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int RSQ_W  = 2 * CFG_BITS;
	localparam int CMP_W  = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_TOL   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REARM_RAD  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_DELAY = 2'd2;

	// register reset values
	localparam logic [CFG_BITS-1:0] MOVE_TOL_RST   = 16'd8;
	localparam logic [CFG_BITS-1:0] REARM_RAD_RST  = 16'd16;
	localparam logic [CFG_BITS-1:0] HOLD_DELAY_RST = 16'd500;

	typedef enum logic [1:0] {
		CMD_DOWN = 2'd0,
		CMD_MOVE = 2'd1,
		CMD_TICK = 2'd2,
		CMD_UP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_PRESS,
		KIND_MOTION,
		KIND_TIMER,
		KIND_RELEASE
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_ARMED   = 2'd1,
		MODE_DRAWING = 2'd2,
		MODE_ABORTED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_ARMED   = 3'd1,
		ACT_ABORT   = 3'd2,
		ACT_PREVIEW = 3'd3,
		ACT_START   = 3'd4,
		ACT_DROP    = 3'd5,
		ACT_COMMIT  = 3'd6
	} action_t;

	typedef struct packed {
		cmd_t                         command;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic [TIME_BITS-1:0]         timestamp;
	} in_item_t;

	typedef struct packed {
		action_t                      action;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
	} out_item_t;

	// classified item carried through the queue
	typedef struct packed {
		kind_t                        kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [TIME_BITS-1:0]         t;
	} op_t;

endpackage

`default_nettype wire

>>> rtl/core/hold_to_draw_gesture_recognizer_top.sv
`default_nettype none

// Press-and-hold pointer gesture recognizer: every accepted event item gives
// exactly one result item (armed, abort, preview, start, drop, commit or
// none). The block sustains one item per clock when the output is not
// stalled; a result passes through the input stage, the two-entry queue
// and the state update that writes the result register. The state update
// in the back end holds two squared-distance compares and two elapsed-time
// compares. Radii are squared when written. Configuration writes must
// happen only while no items are in flight.
module hold_to_draw_gesture_recognizer_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire hdgr_pkg::in_item_t                item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output hdgr_pkg::out_item_t                    result,
	input  wire logic                              cfg_we,
	input  wire logic [hdgr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [hdgr_pkg::CFG_BITS-1:0]     cfg_data
);

	logic          fq_valid;
	logic          fq_ready;
	hdgr_pkg::op_t fq_op;
	logic          qb_valid;
	logic          qb_ready;
	hdgr_pkg::op_t qb_op;

	// accept and classify
	hdgr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.op_valid   (fq_valid),
		.op_ready   (fq_ready),
		.op         (fq_op)
	);

	// decoupling queue
	hdgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_op    (fq_op),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_op     (qb_op)
	);

	// gesture state and results
	hdgr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op_valid     (qb_valid),
		.op_ready     (qb_ready),
		.op           (qb_op),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/core/hdgr_front.sv
`default_nettype none

module hdgr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire hdgr_pkg::in_item_t item,
	output logic                   op_valid,
	input  wire logic              op_ready,
	output hdgr_pkg::op_t          op
);

	logic          valid_s1;
	hdgr_pkg::op_t op_s1;
	hdgr_pkg::op_t op_d;

	// classify the incoming item, positions only matter for press and motion
	always_comb begin
		op_d.x = item.pos_x;
		op_d.y = item.pos_y;
		op_d.t = item.timestamp;
		unique case (item.command)
			hdgr_pkg::CMD_DOWN: op_d.kind = hdgr_pkg::KIND_PRESS;
			hdgr_pkg::CMD_MOVE: op_d.kind = hdgr_pkg::KIND_MOTION;
			hdgr_pkg::CMD_TICK: begin
				op_d.kind = hdgr_pkg::KIND_TIMER;
				op_d.x    = '0;
				op_d.y    = '0;
			end
			default: begin
				op_d.kind = hdgr_pkg::KIND_RELEASE;
				op_d.x    = '0;
				op_d.y    = '0;
			end
		endcase
	end

	// input stage takes a new item whenever its slot is empty or drains this cycle
	assign item_ready = !valid_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1 <= op_d;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

`default_nettype wire

>>> rtl/core/hdgr_queue.sv
`default_nettype none

`include "hold_to_draw_gesture_recognizer_top_defines.svh"

module hdgr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire hdgr_pkg::op_t push_op,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output hdgr_pkg::op_t      pop_op
);

	localparam int DEPTH = hdgr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hdgr_pkg::op_t      slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`HDGR_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
	`HDGR_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + CNT_W'(1), "count missed push")
	`HDGR_ASSERT_IMPL(a_empty_ptrs, cnt_q == '0, wr_ptr_q == rd_ptr_q, "empty queue pointers differ")

endmodule

`default_nettype wire

>>> rtl/core/hdgr_back.sv
`default_nettype none

`include "hold_to_draw_gesture_recognizer_top_defines.svh"

module hdgr_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [hdgr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [hdgr_pkg::CFG_BITS-1:0]        cfg_data,
	input  wire logic                                 op_valid,
	output logic                                      op_ready,
	input  wire hdgr_pkg::op_t                        op,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output hdgr_pkg::out_item_t                       result
);

	localparam int CB = hdgr_pkg::COORD_BITS;
	localparam int TB = hdgr_pkg::TIME_BITS;

	// squared euclidean distance between two points
	function automatic logic [hdgr_pkg::SQ_W-1:0] dist_sq(
		input logic signed [CB-1:0] ax,
		input logic signed [CB-1:0] ay,
		input logic signed [CB-1:0] bx,
		input logic signed [CB-1:0] by
	);
		logic signed [hdgr_pkg::DIFF_W-1:0] dx;
		logic signed [hdgr_pkg::DIFF_W-1:0] dy;
		logic [hdgr_pkg::DIFF_W-1:0]        ux;
		logic [hdgr_pkg::DIFF_W-1:0]        uy;
		logic [hdgr_pkg::SQ_W-1:0]          sx;
		logic [hdgr_pkg::SQ_W-1:0]          sy;
		dx = hdgr_pkg::DIFF_W'(ax) - hdgr_pkg::DIFF_W'(bx);
		dy = hdgr_pkg::DIFF_W'(ay) - hdgr_pkg::DIFF_W'(by);
		ux = dx[hdgr_pkg::DIFF_W-1] ? hdgr_pkg::DIFF_W'(-dx) : hdgr_pkg::DIFF_W'(dx);
		uy = dy[hdgr_pkg::DIFF_W-1] ? hdgr_pkg::DIFF_W'(-dy) : hdgr_pkg::DIFF_W'(dy);
		sx = hdgr_pkg::SQ_W'(ux) * hdgr_pkg::SQ_W'(ux);
		sy = hdgr_pkg::SQ_W'(uy) * hdgr_pkg::SQ_W'(uy);
		return sx + sy;
	endfunction

	// configuration, radii kept squared
	logic [hdgr_pkg::RSQ_W-1:0]    tol_sq_q;
	logic [hdgr_pkg::RSQ_W-1:0]    rearm_sq_q;
	logic [hdgr_pkg::CFG_BITS-1:0] hold_q;

	// gesture state
	hdgr_pkg::mode_t        mode_q;
	hdgr_pkg::mode_t        mode_d;
	logic signed [CB-1:0]   press_x_q, press_y_q, press_x_d, press_y_d;
	logic [TB-1:0]          press_t_q, press_t_d;
	logic signed [CB-1:0]   anchor_x_q, anchor_y_q, anchor_x_d, anchor_y_d;
	logic [TB-1:0]          anchor_t_q, anchor_t_d;
	logic signed [CB-1:0]   drop_x_q, drop_y_q, drop_x_d, drop_y_d;
	logic                   drop_en_q, drop_en_d;

	// result register
	logic                   res_valid_q;
	hdgr_pkg::out_item_t    res_q;
	hdgr_pkg::out_item_t    res_d;

	logic                   pop;
	logic signed [CB-1:0]   base_x, base_y;
	logic                   far_tol;
	logic                   far_rearm;
	logic [TB-1:0]          el_press;
	logic [TB-1:0]          el_anchor;
	logic                   hold_press;
	logic                   hold_anchor;

	assign pop      = op_valid && (!res_valid_q || result_ready);
	assign op_ready = !res_valid_q || result_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_sq_q   <= hdgr_pkg::RSQ_W'(hdgr_pkg::MOVE_TOL_RST) *
				hdgr_pkg::RSQ_W'(hdgr_pkg::MOVE_TOL_RST);
			rearm_sq_q <= hdgr_pkg::RSQ_W'(hdgr_pkg::REARM_RAD_RST) *
				hdgr_pkg::RSQ_W'(hdgr_pkg::REARM_RAD_RST);
			hold_q     <= hdgr_pkg::HOLD_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hdgr_pkg::REG_MOVE_TOL: begin
					tol_sq_q <= hdgr_pkg::RSQ_W'(cfg_data) * hdgr_pkg::RSQ_W'(cfg_data);
				end
				hdgr_pkg::REG_REARM_RAD: begin
					rearm_sq_q <= hdgr_pkg::RSQ_W'(cfg_data) * hdgr_pkg::RSQ_W'(cfg_data);
				end
				hdgr_pkg::REG_HOLD_DELAY: begin
					hold_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// distance checks: tolerance from press point while armed, else anchor; rearm from drop point
	assign base_x    = (mode_q == hdgr_pkg::MODE_ARMED) ? press_x_q : anchor_x_q;
	assign base_y    = (mode_q == hdgr_pkg::MODE_ARMED) ? press_y_q : anchor_y_q;
	assign far_tol   = hdgr_pkg::CMP_W'(dist_sq(op.x, op.y, base_x, base_y)) >
		hdgr_pkg::CMP_W'(tol_sq_q);
	assign far_rearm = hdgr_pkg::CMP_W'(dist_sq(op.x, op.y, drop_x_q, drop_y_q)) >
		hdgr_pkg::CMP_W'(rearm_sq_q);

	// wrapping elapsed times
	assign el_press    = op.t - press_t_q;
	assign el_anchor   = op.t - anchor_t_q;
	assign hold_press  = el_press >= TB'(hold_q);
	assign hold_anchor = el_anchor >= TB'(hold_q);

	// next state
	always_comb begin
		mode_d     = mode_q;
		press_x_d  = press_x_q;
		press_y_d  = press_y_q;
		press_t_d  = press_t_q;
		anchor_x_d = anchor_x_q;
		anchor_y_d = anchor_y_q;
		anchor_t_d = anchor_t_q;
		drop_x_d   = drop_x_q;
		drop_y_d   = drop_y_q;
		drop_en_d  = drop_en_q;
		unique case (op.kind)
			hdgr_pkg::KIND_PRESS: begin
				mode_d     = hdgr_pkg::MODE_ARMED;
				press_x_d  = op.x;
				press_y_d  = op.y;
				press_t_d  = op.t;
				anchor_x_d = op.x;
				anchor_y_d = op.y;
				anchor_t_d = op.t;
				drop_en_d  = 1'b0;
			end
			hdgr_pkg::KIND_MOTION: begin
				if (mode_q == hdgr_pkg::MODE_ARMED) begin
					if (far_tol) begin
						mode_d = hdgr_pkg::MODE_ABORTED;
					end
				end else if (mode_q == hdgr_pkg::MODE_DRAWING) begin
					if (far_tol) begin
						anchor_x_d = op.x;
						anchor_y_d = op.y;
						anchor_t_d = op.t;
					end
					if (far_rearm) begin
						drop_en_d = 1'b1;
					end
				end
			end
			hdgr_pkg::KIND_TIMER: begin
				if (mode_q == hdgr_pkg::MODE_ARMED) begin
					if (hold_press) begin
						mode_d     = hdgr_pkg::MODE_DRAWING;
						drop_x_d   = press_x_q;
						drop_y_d   = press_y_q;
						anchor_x_d = press_x_q;
						anchor_y_d = press_y_q;
						anchor_t_d = op.t;
						drop_en_d  = 1'b0;
					end
				end else if (mode_q == hdgr_pkg::MODE_DRAWING) begin
					if (drop_en_q && hold_anchor) begin
						drop_en_d  = 1'b0;
						drop_x_d   = anchor_x_q;
						drop_y_d   = anchor_y_q;
						anchor_t_d = op.t;
					end
				end
			end
			default: begin
				mode_d    = hdgr_pkg::MODE_IDLE;
				drop_en_d = 1'b0;
			end
		endcase
	end

	// result for the current item
	always_comb begin
		res_d.action = hdgr_pkg::ACT_NONE;
		res_d.out_x  = '0;
		res_d.out_y  = '0;
		unique case (op.kind)
			hdgr_pkg::KIND_PRESS: begin
				res_d.action = hdgr_pkg::ACT_ARMED;
			end
			hdgr_pkg::KIND_MOTION: begin
				if (mode_q == hdgr_pkg::MODE_ARMED) begin
					if (far_tol) begin
						res_d.action = hdgr_pkg::ACT_ABORT;
					end
				end else if (mode_q == hdgr_pkg::MODE_DRAWING) begin
					res_d.action = hdgr_pkg::ACT_PREVIEW;
					res_d.out_x  = op.x;
					res_d.out_y  = op.y;
				end
			end
			hdgr_pkg::KIND_TIMER: begin
				if (mode_q == hdgr_pkg::MODE_ARMED) begin
					if (hold_press) begin
						res_d.action = hdgr_pkg::ACT_START;
						res_d.out_x  = press_x_q;
						res_d.out_y  = press_y_q;
					end
				end else if (mode_q == hdgr_pkg::MODE_DRAWING) begin
					if (drop_en_q && hold_anchor) begin
						res_d.action = hdgr_pkg::ACT_DROP;
						res_d.out_x  = anchor_x_q;
						res_d.out_y  = anchor_y_q;
					end
				end
			end
			default: begin
				if (mode_q == hdgr_pkg::MODE_DRAWING) begin
					res_d.action = hdgr_pkg::ACT_COMMIT;
				end
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= hdgr_pkg::MODE_IDLE;
			press_x_q  <= '0;
			press_y_q  <= '0;
			press_t_q  <= '0;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			anchor_t_q <= '0;
			drop_x_q   <= '0;
			drop_y_q   <= '0;
			drop_en_q  <= 1'b0;
		end else if (pop) begin
			mode_q     <= mode_d;
			press_x_q  <= press_x_d;
			press_y_q  <= press_y_d;
			press_t_q  <= press_t_d;
			anchor_x_q <= anchor_x_d;
			anchor_y_q <= anchor_y_d;
			anchor_t_q <= anchor_t_d;
			drop_x_q   <= drop_x_d;
			drop_y_q   <= drop_y_d;
			drop_en_q  <= drop_en_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`HDGR_ASSERT_NEXT(a_preview, pop && op.kind == hdgr_pkg::KIND_MOTION && mode_q == hdgr_pkg::MODE_DRAWING, res_q.action == hdgr_pkg::ACT_PREVIEW, "drawing move gave no preview")
	`HDGR_ASSERT_NEXT(a_start_mode, pop && res_d.action == hdgr_pkg::ACT_START, mode_q == hdgr_pkg::MODE_DRAWING && !drop_en_q, "start did not enter drawing")
	`HDGR_ASSERT_IMPL(a_drop_en_mode, drop_en_q, mode_q == hdgr_pkg::MODE_DRAWING, "drop enabled outside drawing")

endmodule

`default_nettype wire
